// ===== src/bfa_pkg.sv =====
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int DEF_MAX_BLOCKS = 1024;
  localparam int HDR_BYTES      = 16;
  localparam int BS_W           = 17;
  localparam int BS_RESET       = 64;
  localparam int BS_MIN         = 16;
  localparam int BS_MAX         = 65536;
  localparam int REQ_W          = 32;
  localparam int DVD_W          = REQ_W + 1;
  localparam int IDX_W          = 10;
  localparam int OFF_W          = 27;
  localparam int ADDR_W         = 3;

  // register index, taken from paddr[2]
  localparam logic REG_BLOCK_SIZE = 1'b0;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [BS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic             rem_nz;
  } div_rsp_t;

endpackage

// ===== src/bfa_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module bfa_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bfa_pkg::div_req_t  req,
  output bfa_pkg::div_rsp_t  rsp
);

  logic [bfa_pkg::DVD_W-1:0] q_r, q_nxt;
  logic [bfa_pkg::BS_W-1:0]  rem_r, rem_nxt;
  logic [5:0]                cnt_r, cnt_nxt;
  logic                      done_r, done_nxt;
  logic [bfa_pkg::BS_W:0]    rem_sh;
  logic                      ge;

  assign rem_sh = {rem_r, q_r[bfa_pkg::DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, req.divisor};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt   = req.dividend;
      rem_nxt = '0;
      cnt_nxt = 6'(bfa_pkg::DVD_W);
    end else if (cnt_r != 6'd0) begin
      rem_nxt = ge ? bfa_pkg::BS_W'(rem_sh - {1'b0, req.divisor})
                   : rem_sh[bfa_pkg::BS_W-1:0];
      q_nxt   = {q_r[bfa_pkg::DVD_W-2:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      done_nxt = (cnt_r == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.quot   = q_r;
  assign rsp.rem_nz = rem_r != '0;

endmodule

// ===== src/best_fit_block_allocator_top.sv =====
`timescale 1ns / 1ps

// Best-fit block allocator over a pool of MAX_BLOCKS blocks, one item at a time.
// Run headers (size, previous size, free mark, allocated-head mark) live in one
// single-port-read, single-port-write memory with a registered read. After reset
// a clearing pass writes every header with in_ready low; configuration writes
// are taken throughout. An allocate first runs the block-count divider (one
// quotient bit a cycle), then walks the run chain from block 0, one run a cycle
// (up to MAX_BLOCKS runs), then makes up to three header writes and posts the
// result. A free does header reads and writes for the merge in the FCHK and FW
// states. The result sits in an output register, so the next item is taken while
// it waits.
module best_fit_block_allocator_top #(
  parameter int MAX_BLOCKS = bfa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [bfa_pkg::REQ_W-1:0]   in_request_bytes,
  input  logic [bfa_pkg::IDX_W-1:0]   in_block_index,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_ok,
  output logic [bfa_pkg::IDX_W-1:0]   out_start_block,
  output logic [bfa_pkg::OFF_W-1:0]   out_payload_offset,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfa_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int PW = $clog2(MAX_BLOCKS);     // header index
  localparam int SW = $clog2(MAX_BLOCKS + 1); // run size
  localparam int NW = SW + 1;                 // block need, saturated
  localparam int MW = PW + bfa_pkg::BS_W;     // offset product

  typedef struct packed {
    logic          head;
    logic          free;
    logic [SW-1:0] prev;
    logic [SW-1:0] size;
  } entry_t;

  typedef enum logic [13:0] {
    ST_CLR   = 14'b00000000000001,
    ST_IDLE  = 14'b00000000000010,
    ST_DIV   = 14'b00000000000100,
    ST_WALK  = 14'b00000000001000,
    ST_AW1   = 14'b00000000010000,
    ST_AW2   = 14'b00000000100000,
    ST_AW3   = 14'b00000001000000,
    ST_FCHK0 = 14'b00000010000000,
    ST_FCHK1 = 14'b00000100000000,
    ST_FCHK2 = 14'b00001000000000,
    ST_FW1   = 14'b00010000000000,
    ST_FW2   = 14'b00100000000000,
    ST_FW3   = 14'b01000000000000,
    ST_RES   = 14'b10000000000000
  } state_t;

  // header memory
  entry_t        mem [MAX_BLOCKS];
  entry_t        rdata_r;
  logic          re, we;
  logic [PW-1:0] ra, wa;
  entry_t        wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rdata_r <= mem[ra];
  end

  // configuration register
  logic [bfa_pkg::BS_W-1:0] cfg_bs_r;
  logic [bfa_pkg::BS_W-1:0] bs_eff;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == bfa_pkg::REG_BLOCK_SIZE);
  assign prdata = (paddr[2] == bfa_pkg::REG_BLOCK_SIZE) ? 32'(cfg_bs_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_bs_r <= bfa_pkg::BS_W'(bfa_pkg::BS_RESET);
    end else if (cfg_wr) begin
      cfg_bs_r <= pwdata[bfa_pkg::BS_W-1:0];
    end
  end

  // out-of-range block sizes are clamped
  always_comb begin
    bs_eff = cfg_bs_r;
    if (cfg_bs_r < bfa_pkg::BS_W'(bfa_pkg::BS_MIN)) bs_eff = bfa_pkg::BS_W'(bfa_pkg::BS_MIN);
    if (cfg_bs_r > bfa_pkg::BS_W'(bfa_pkg::BS_MAX)) bs_eff = bfa_pkg::BS_W'(bfa_pkg::BS_MAX);
  end

  // block-count divider
  bfa_pkg::div_req_t div_req;
  bfa_pkg::div_rsp_t div_rsp;

  bfa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer state
  state_t        state_r, state_nxt;
  logic [PW-1:0] clr_r, clr_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [NW-1:0] need_r, need_nxt;
  logic          found_r, found_nxt;
  logic [PW-1:0] best_pos_r, best_pos_nxt;
  logic [SW-1:0] best_size_r, best_size_nxt;
  logic [SW-1:0] best_prev_r, best_prev_nxt;
  logic          is_alloc_r, is_alloc_nxt;
  logic          ok_r, ok_nxt;
  logic [PW-1:0] cur_r, cur_nxt;
  logic [SW-1:0] cur_size_r, cur_size_nxt;
  logic [SW-1:0] cur_prev_r, cur_prev_nxt;
  logic          low_try_r, low_try_nxt;
  logic          low_m_r, low_m_nxt;
  entry_t        low_e_r, low_e_nxt;
  logic          nv_r, nv_nxt;           // a run follows the one in hand
  logic [PW-1:0] naddr_r, naddr_nxt;
  logic [SW-1:0] nsize_r, nsize_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_ok_r, out_ok_nxt;
  logic [bfa_pkg::IDX_W-1:0] out_start_r, out_start_nxt;
  logic [bfa_pkg::OFF_W-1:0] out_off_r, out_off_nxt;

  // datapath helpers
  logic [SW:0]          walk_sum;
  logic                 fit;
  logic [bfa_pkg::DVD_W:0] need_full;
  logic [SW:0]          sum_a, sum_b;
  logic [SW-1:0]        lo_size;
  logic [PW-1:0]        new_pos;
  logic [SW:0]          end_sum;
  logic [MW-1:0]        prod;

  assign in_ready = (state_r == ST_IDLE);
  assign walk_sum = (SW+1)'(pos_r) + (SW+1)'(rdata_r.size);
  assign fit      = rdata_r.free && ({1'b0, rdata_r.size} >= need_r)
                    && (!found_r || rdata_r.size < best_size_r);
  assign need_full = (bfa_pkg::DVD_W+1)'(div_rsp.quot) + (bfa_pkg::DVD_W+1)'(div_rsp.rem_nz);
  assign prod     = MW'(best_pos_r) * MW'(bs_eff);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pos_nxt       = pos_r;
    need_nxt      = need_r;
    found_nxt     = found_r;
    best_pos_nxt  = best_pos_r;
    best_size_nxt = best_size_r;
    best_prev_nxt = best_prev_r;
    is_alloc_nxt  = is_alloc_r;
    ok_nxt        = ok_r;
    cur_nxt       = cur_r;
    cur_size_nxt  = cur_size_r;
    cur_prev_nxt  = cur_prev_r;
    low_try_nxt   = low_try_r;
    low_m_nxt     = low_m_r;
    low_e_nxt     = low_e_r;
    nv_nxt        = nv_r;
    naddr_nxt     = naddr_r;
    nsize_nxt     = nsize_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_start_nxt = out_start_r;
    out_off_nxt   = out_off_r;
    re = 1'b0;
    ra = '0;
    we = 1'b0;
    wa = '0;
    wd = '0;
    div_req.start    = 1'b0;
    div_req.dividend = bfa_pkg::DVD_W'(in_request_bytes) + bfa_pkg::DVD_W'(bfa_pkg::HDR_BYTES);
    div_req.divisor  = bs_eff;
    sum_a   = '0;
    sum_b   = '0;
    lo_size = '0;
    new_pos = cur_r;
    end_sum = '0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_CLR: begin
        // header sweep, the whole pool is one free run at block 0
        we = 1'b1;
        wa = clr_r;
        if (clr_r == '0) begin
          wd.free = 1'b1;
          wd.size = SW'(MAX_BLOCKS);
        end
        clr_nxt = clr_r + PW'(1);
        if (clr_r == PW'(MAX_BLOCKS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == bfa_pkg::KIND_ALLOC) begin
            is_alloc_nxt  = 1'b1;
            found_nxt     = 1'b0;
            div_req.start = 1'b1;
            state_nxt     = ST_DIV;
          end else begin
            is_alloc_nxt = 1'b0;
            if (32'(in_block_index) >= 32'(MAX_BLOCKS)) begin
              ok_nxt    = 1'b0;
              state_nxt = ST_RES;
            end else begin
              cur_nxt   = PW'(in_block_index);
              re        = 1'b1;
              ra        = PW'(in_block_index);
              state_nxt = ST_FCHK0;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          // anything beyond the pool saturates
          if (need_full > (bfa_pkg::DVD_W+1)'(MAX_BLOCKS)) need_nxt = '1;
          else                                             need_nxt = NW'(need_full);
          pos_nxt   = '0;
          re        = 1'b1;
          ra        = '0;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        // one run header per cycle
        if (rdata_r.size != '0 && fit) begin
          found_nxt     = 1'b1;
          best_pos_nxt  = pos_r;
          best_size_nxt = rdata_r.size;
          best_prev_nxt = rdata_r.prev;
        end
        if (rdata_r.size == '0 || walk_sum >= (SW+1)'(MAX_BLOCKS)) begin
          if (found_nxt) begin
            state_nxt = ST_AW1;
          end else begin
            ok_nxt    = 1'b0;
            state_nxt = ST_RES;
          end
        end else begin
          pos_nxt = walk_sum[PW-1:0];
          re      = 1'b1;
          ra      = walk_sum[PW-1:0];
        end
      end
      ST_AW1: begin
        we        = 1'b1;
        wa        = best_pos_r;
        wd.head   = 1'b1;
        wd.free   = 1'b0;
        wd.prev   = best_prev_r;
        wd.size   = SW'(need_r);
        ok_nxt    = 1'b1;
        sum_a     = (SW+1)'(best_pos_r) + (SW+1)'(best_size_r);
        nv_nxt    = sum_a < (SW+1)'(MAX_BLOCKS);
        naddr_nxt = sum_a[PW-1:0];
        if ({1'b0, best_size_r} > need_r) begin
          re        = 1'b1;
          ra        = sum_a[PW-1:0];
          state_nxt = ST_AW2;
        end else begin
          state_nxt = ST_RES;
        end
      end
      ST_AW2: begin
        // split remainder
        we      = 1'b1;
        wa      = PW'((SW+1)'(best_pos_r) + (SW+1)'(need_r[SW-1:0]));
        wd.head = 1'b0;
        wd.free = 1'b1;
        wd.prev = SW'(need_r);
        wd.size = best_size_r - SW'(need_r);
        state_nxt = nv_r ? ST_AW3 : ST_RES;
      end
      ST_AW3: begin
        we        = 1'b1;
        wa        = naddr_r;
        wd        = rdata_r;
        wd.prev   = best_size_r - SW'(need_r);
        state_nxt = ST_RES;
      end
      ST_FCHK0: begin
        cur_size_nxt = rdata_r.size;
        cur_prev_nxt = rdata_r.prev;
        sum_a        = (SW+1)'(cur_r) + (SW+1)'(rdata_r.size);
        nv_nxt       = sum_a < (SW+1)'(MAX_BLOCKS);
        naddr_nxt    = sum_a[PW-1:0];
        low_try_nxt  = (rdata_r.prev != '0) && (rdata_r.prev <= SW'(cur_r));
        if (!rdata_r.head || rdata_r.size == '0 || sum_a > (SW+1)'(MAX_BLOCKS)) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_RES;
        end else begin
          re        = low_try_nxt;
          ra        = PW'(SW'(cur_r) - rdata_r.prev);
          state_nxt = ST_FCHK1;
        end
      end
      ST_FCHK1: begin
        low_m_nxt = low_try_r && rdata_r.free;
        low_e_nxt = rdata_r;
        re        = nv_r;
        ra        = naddr_r;
        state_nxt = ST_FCHK2;
      end
      ST_FCHK2: begin
        // merge sizes and the new run position
        lo_size = low_m_r ? cur_prev_r : '0;
        sum_b   = (SW+1)'(cur_size_r) + (SW+1)'(lo_size)
                + ((nv_r && rdata_r.free) ? (SW+1)'(rdata_r.size) : '0);
        nsize_nxt = SW'(sum_b);
        new_pos   = low_m_r ? PW'(SW'(cur_r) - cur_prev_r) : cur_r;
        if (nv_r && rdata_r.free) begin
          we      = 1'b1;
          wa      = naddr_r;
          wd      = rdata_r;
          wd.free = 1'b0;
        end
        end_sum   = (SW+1)'(new_pos) + (SW+1)'(SW'(sum_b));
        nv_nxt    = end_sum < (SW+1)'(MAX_BLOCKS);
        naddr_nxt = end_sum[PW-1:0];
        re        = nv_nxt;
        ra        = end_sum[PW-1:0];
        state_nxt = ST_FW1;
      end
      ST_FW1: begin
        we      = 1'b1;
        wa      = cur_r;
        wd.head = 1'b0;
        wd.prev = cur_prev_r;
        if (low_m_r) begin
          wd.free = 1'b0;
          wd.size = cur_size_r;
        end else begin
          wd.free = 1'b1;
          wd.size = nsize_r;
        end
        state_nxt = ST_FW2;
      end
      ST_FW2: begin
        if (low_m_r) begin
          we      = 1'b1;
          wa      = PW'(SW'(cur_r) - cur_prev_r);
          wd      = low_e_r;
          wd.free = 1'b1;
          wd.size = nsize_r;
        end
        state_nxt = ST_FW3;
      end
      ST_FW3: begin
        if (nv_r) begin
          we      = 1'b1;
          wa      = naddr_r;
          wd      = rdata_r;
          wd.prev = nsize_r;
        end
        ok_nxt    = 1'b1;
        state_nxt = ST_RES;
      end
      ST_RES: begin
        // post once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          if (ok_r && is_alloc_r) begin
            out_start_nxt = bfa_pkg::IDX_W'(best_pos_r);
            out_off_nxt   = bfa_pkg::OFF_W'(prod + MW'(bfa_pkg::HDR_BYTES));
          end else begin
            out_start_nxt = '0;
            out_off_nxt   = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
    pos_r       <= pos_nxt;
    need_r      <= need_nxt;
    best_pos_r  <= best_pos_nxt;
    best_size_r <= best_size_nxt;
    best_prev_r <= best_prev_nxt;
    is_alloc_r  <= is_alloc_nxt;
    ok_r        <= ok_nxt;
    cur_r       <= cur_nxt;
    cur_size_r  <= cur_size_nxt;
    cur_prev_r  <= cur_prev_nxt;
    low_try_r   <= low_try_nxt;
    low_m_r     <= low_m_nxt;
    low_e_r     <= low_e_nxt;
    nv_r        <= nv_nxt;
    naddr_r     <= naddr_nxt;
    nsize_r     <= nsize_nxt;
    out_ok_r    <= out_ok_nxt;
    out_start_r <= out_start_nxt;
    out_off_r   <= out_off_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_start_block    = out_start_r;
  assign out_payload_offset = out_off_r;

endmodule

// ===== src/bfa_checker.sv =====
`timescale 1ns / 1ps

module bfa_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_ok,
  input logic [bfa_pkg::IDX_W-1:0]  out_start_block,
  input logic [bfa_pkg::OFF_W-1:0]  out_payload_offset,
  input logic                       pready
);

  // a held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_start_block)
                                && $stable(out_payload_offset) && $stable(out_ok))
    else $error("result beat dropped or changed while stalled");

  // failed beats carry no position
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_start_block == '0 && out_payload_offset == '0)
    else $error("non-zero position on a result without a run");

  // clearing pass holds off input right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_ready && !out_valid)
    else $error("block active right after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind best_fit_block_allocator_top bfa_checker u_bfa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_ok             (out_ok),
  .out_start_block    (out_start_block),
  .out_payload_offset (out_payload_offset),
  .pready             (pready)
);

// ===== test/bfa_alloc_checker.sv =====
`timescale 1ns / 1ps

module bfa_alloc_checker #(
  parameter int MAX_BLOCKS = bfa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_kind,
  input  logic [bfa_pkg::REQ_W-1:0]  in_request_bytes,
  input  logic [bfa_pkg::IDX_W-1:0]  in_block_index,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_ok,
  input  logic [bfa_pkg::IDX_W-1:0]  out_start_block,
  input  logic [bfa_pkg::OFF_W-1:0]  out_payload_offset,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bfa_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int                         mismatches,
  output int                         beats_waiting
);

  typedef struct packed {
    logic                      ok;
    logic [bfa_pkg::IDX_W-1:0] start_block;
    logic [bfa_pkg::OFF_W-1:0] payload_offset;
  } alloc_result_t;

  alloc_result_t expected_results[$];

  logic [bfa_pkg::BS_W-1:0] block_size_reg;
  int unsigned     run_len [MAX_BLOCKS];
  int unsigned     prev_len[MAX_BLOCKS];
  bit              is_free [MAX_BLOCKS];
  bit              is_head [MAX_BLOCKS];

  function automatic longint unsigned clamped_block_size();
    longint unsigned b;
    b = 64'(block_size_reg);
    if (b < bfa_pkg::BS_MIN) b = bfa_pkg::BS_MIN;
    if (b > bfa_pkg::BS_MAX) b = bfa_pkg::BS_MAX;
    return b;
  endfunction

  task automatic allocate_run(input logic [bfa_pkg::REQ_W-1:0] bytes,
                              output alloc_result_t r);
    longint unsigned bs, total, need, pos, best_pos, best_len, sz;
    bit found;
    bs = clamped_block_size();
    total = 64'(bytes) + 64'(bfa_pkg::HDR_BYTES);
    need = (total + bs - 1) / bs;
    pos = 0;
    best_pos = 0;
    best_len = 0;
    found = 0;
    r = '0;
    while (pos < MAX_BLOCKS && run_len[pos] != 0) begin
      sz = 64'(run_len[pos]);
      if (is_free[pos] && sz >= need && (!found || sz < best_len)) begin
        found = 1;
        best_pos = pos;
        best_len = sz;
      end
      pos += sz;
    end
    if (found) begin
      is_free[best_pos] = 0;
      is_head[best_pos] = 1;
      // split off the remainder as a new free run
      if (need < best_len) begin
        prev_len[best_pos + need] = 32'(need);
        run_len[best_pos + need]  = 32'(best_len - need);
        is_free[best_pos + need]  = 1;
        is_head[best_pos + need]  = 0;
        if (best_pos + best_len < MAX_BLOCKS) begin
          prev_len[best_pos + best_len] = 32'(best_len - need);
        end
      end
      run_len[best_pos] = 32'(need);
      r.ok = 1;
      r.start_block = best_pos[bfa_pkg::IDX_W-1:0];
      r.payload_offset = bfa_pkg::OFF_W'(best_pos * bs + 64'(bfa_pkg::HDR_BYTES));
    end
  endtask

  task automatic release_run(input logic [bfa_pkg::IDX_W-1:0] idx, output alloc_result_t r);
    longint unsigned cur, sz, pv, merged_pos, merged_len, nxt;
    cur = 64'(idx);
    r = '0;
    if (cur >= MAX_BLOCKS || !is_head[cur]) return;
    sz = 64'(run_len[cur]);
    pv = 64'(prev_len[cur]);
    if (sz == 0 || cur + sz > MAX_BLOCKS) return;
    is_head[cur] = 0;
    merged_pos = cur;
    merged_len = sz;
    // merge down, then up
    if (pv != 0 && pv <= cur && is_free[cur - pv]) begin
      merged_pos = cur - pv;
      merged_len += pv;
    end
    nxt = cur + sz;
    if (nxt < MAX_BLOCKS && is_free[nxt]) begin
      merged_len += 64'(run_len[nxt]);
      is_free[nxt] = 0;
    end
    if (merged_pos != cur) is_free[cur] = 0;
    is_free[merged_pos] = 1;
    run_len[merged_pos] = 32'(merged_len);
    if (merged_pos + merged_len < MAX_BLOCKS) begin
      prev_len[merged_pos + merged_len] = 32'(merged_len);
    end
    r.ok = 1;
  endtask

  always @(posedge clk) begin
    alloc_result_t r;
    if (!rst_n) begin
      block_size_reg = bfa_pkg::BS_W'(bfa_pkg::BS_RESET);
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        run_len[i] = 0;
        prev_len[i] = 0;
        is_free[i] = 0;
        is_head[i] = 0;
      end
      run_len[0] = MAX_BLOCKS;
      is_free[0] = 1;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == bfa_pkg::REG_BLOCK_SIZE) begin
        block_size_reg = pwdata[bfa_pkg::BS_W-1:0];
      end
      if (in_valid && in_ready) begin
        if (in_kind == bfa_pkg::KIND_ALLOC) allocate_run(in_request_bytes, r);
        else release_run(in_block_index, r);
        expected_results.push_back(r);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          r = expected_results.pop_front();
          if (out_ok !== r.ok || out_start_block !== r.start_block ||
              out_payload_offset !== r.payload_offset) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t: ok %0d/%0d start %0d/%0d offset %0d/%0d (exp/act)",
                       $realtime, r.ok, out_ok, r.start_block, out_start_block,
                       r.payload_offset, out_payload_offset);
            end
          end
        end
      end
    end
    beats_waiting = expected_results.size();
  end

endmodule

// ===== test/best_fit_block_allocator_top_tb.sv =====
`timescale 1ns / 1ps

module best_fit_block_allocator_top_tb;

  logic                         clk = 0;
  logic                         rst_n = 0;
  logic                         in_valid = 0;
  logic                         in_ready;
  logic                         in_kind = bfa_pkg::KIND_ALLOC;
  logic [bfa_pkg::REQ_W-1:0]    in_request_bytes = '0;
  logic [bfa_pkg::IDX_W-1:0]    in_block_index = '0;
  logic                         out_valid;
  logic                         out_ready = 0;
  logic                         out_ok;
  logic [bfa_pkg::IDX_W-1:0]    out_start_block;
  logic [bfa_pkg::OFF_W-1:0]    out_payload_offset;
  logic                         psel = 0;
  logic                         penable = 0;
  logic                         pwrite = 0;
  logic [bfa_pkg::ADDR_W-1:0]   paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  int mismatches;
  int beats_waiting;

  // idle percentages per side, long receiver hold request
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;

  // bookkeeping for stimulus: kinds in flight and currently allocated starts
  logic                      kinds_in_flight[$];
  logic [bfa_pkg::IDX_W-1:0] live_starts[$];
  int          beats_sent = 0;
  int          beats_done = 0;
  int unsigned cur_block_size = bfa_pkg::BS_RESET;

  always #5 clk = ~clk;

  best_fit_block_allocator_top i_dut (.*);

  bfa_alloc_checker i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_request_bytes, .in_block_index,
    .out_valid, .out_ready, .out_ok, .out_start_block, .out_payload_offset,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .beats_waiting
  );

  // receiver: random stalls, plus one long hold counted here
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // collect allocated starts so frees can target real runs
  always @(posedge clk) begin
    logic k;
    if (rst_n && out_valid && out_ready) begin
      beats_done++;
      if (kinds_in_flight.size() > 0) begin
        k = kinds_in_flight.pop_front();
        if (k == bfa_pkg::KIND_ALLOC && out_ok) live_starts.push_back(out_start_block);
      end
    end
  end

  task automatic send_beat(input logic kind, input logic [bfa_pkg::REQ_W-1:0] bytes,
                           input logic [bfa_pkg::IDX_W-1:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_request_bytes <= bytes;
    in_block_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    kinds_in_flight.push_back(kind);
    beats_sent++;
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (beats_done != beats_sent) @(posedge clk);
    // quiet gap before touching the configuration
    repeat (40) @(posedge clk);
  endtask

  task automatic write_block_size(input logic [31:0] value, input int unsigned eff);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {bfa_pkg::REG_BLOCK_SIZE, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_block_size = eff;
  endtask

  task automatic random_beats(input int count, input bit do_hold);
    int unsigned pick;
    logic [bfa_pkg::REQ_W-1:0] bytes;
    for (int n = 0; n < count; n++) begin
      if (do_hold && n == 10) hold_req = 1;
      if ($urandom_range(99) < 62) begin
        pick = $urandom_range(99);
        if (pick < 80) bytes = $urandom_range(0, cur_block_size * 24);
        else if (pick < 90) bytes = $urandom_range(0, 15);
        else bytes = $urandom;
        send_beat(bfa_pkg::KIND_ALLOC, bytes, '0);
      end else if (live_starts.size() > 0 && $urandom_range(99) < 75) begin
        pick = $urandom_range(live_starts.size() - 1);
        send_beat(bfa_pkg::KIND_FREE, $urandom, live_starts[pick]);
        live_starts.delete(pick);
      end else begin
        // stray free: inside a run, already free or never allocated
        send_beat(bfa_pkg::KIND_FREE, $urandom,
                  bfa_pkg::IDX_W'($urandom_range(0, 1023)));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_block_size(64, 64);
    send_idle_pct = 29;
    recv_idle_pct = 52;

    // directed: smallest and largest requests, splits, merges, stray frees
    send_beat(bfa_pkg::KIND_ALLOC, 32'd0, '0);
    send_beat(bfa_pkg::KIND_ALLOC, 32'hFFFF_FFFF, '0);
    send_beat(bfa_pkg::KIND_ALLOC, 32'd48, '0);
    send_beat(bfa_pkg::KIND_FREE, 32'd0, 10'd0);
    send_beat(bfa_pkg::KIND_FREE, 32'd0, 10'd0);
    send_beat(bfa_pkg::KIND_FREE, 32'hFFFF_FFFF, 10'd1023);
    send_beat(bfa_pkg::KIND_ALLOC, 32'd100, '0);
    send_beat(bfa_pkg::KIND_ALLOC, 32'd10, '0);
    send_beat(bfa_pkg::KIND_FREE, 32'd0, 10'd1);
    send_beat(bfa_pkg::KIND_FREE, 32'd0, 10'd2);
    send_beat(bfa_pkg::KIND_ALLOC, 32'd65456, '0);
    send_beat(bfa_pkg::KIND_ALLOC, 32'd0, '0);
    send_beat(bfa_pkg::KIND_FREE, 32'd0, 10'd1);
    send_beat(bfa_pkg::KIND_FREE, 32'd0, 10'd0);
    send_beat(bfa_pkg::KIND_ALLOC, 32'd65520, '0);
    send_beat(bfa_pkg::KIND_FREE, 32'd0, 10'd0);
    send_beat(bfa_pkg::KIND_FREE, 32'd0, 10'd3);
    send_beat(bfa_pkg::KIND_ALLOC, 32'd65521, '0);
    drain_and_settle();
    live_starts.delete();

    random_beats(180, 0);
    drain_and_settle();

    // below the minimum block size, then the other idle mix
    write_block_size(5, bfa_pkg::BS_MIN);
    send_idle_pct = 52;
    recv_idle_pct = 29;
    random_beats(130, 0);
    drain_and_settle();

    write_block_size(1000, 1000);
    random_beats(100, 0);
    drain_and_settle();

    // above the maximum, no idling, long receiver hold to back up the input
    write_block_size(32'h0001_FFFF, bfa_pkg::BS_MAX);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_beats(100, 1);
    drain_and_settle();

    write_block_size(bfa_pkg::BS_MIN, bfa_pkg::BS_MIN);
    random_beats(60, 0);
    drain_and_settle();

    if (mismatches == 0 && beats_waiting == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== best_fit_block_allocator_top.f =====
src/bfa_pkg.sv
src/bfa_div.sv
src/best_fit_block_allocator_top.sv
src/bfa_checker.sv
test/bfa_alloc_checker.sv
test/best_fit_block_allocator_top_tb.sv
